// ----- hw/rtl/lrukv_pkg.sv -----
package lrukv_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;
  localparam int OCC_W  = 4;

  // capacity register after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EVICT
  } lrukv_state_t;

endpackage

// ----- hw/rtl/lrukv_store.sv -----
module lrukv_store
  import lrukv_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_key,
  input  logic [DATA_W-1:0] wr_value,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_key,
  output logic [DATA_W-1:0] rd_value
);

  logic [DATA_W-1:0] keys   [DEPTH];
  logic [DATA_W-1:0] values [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr]   <= wr_key;
      values[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
  end

endmodule

// ----- hw/rtl/lru_key_value_cache_unit.sv -----
// sequence: an access scans the store, then resolves hit or miss; a miss at capacity
//   adds an evict step; the result is registered once the output register can take it
// throughput: one access at a time, no new one until commit; the scan is paced by
//   the single key compare walking the store one entry per cycle through its read port
// reset: synchronous, clears valid bits, ranks and occupancy, capacity returns to 8;
//   key and value storage is not cleared and needs no clearing pass
module lru_key_value_cache_unit
  import lrukv_pkg::*;
#(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic                     evicted,
  output logic signed [DATA_W-1:0] evicted_key,
  output logic signed [DATA_W-1:0] evicted_value,
  output logic [OCC_W-1:0]         occupancy
);

  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW   = AW;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  lrukv_state_t state, state_next;

  // configuration
  logic [CFG_W-1:0] capacity;

  // per-entry control state in flops
  logic [MAX_ENTRIES-1:0] valid;
  logic [RW-1:0]          rank [MAX_ENTRIES];
  logic [CW-1:0]          count;

  // latched transfer payload
  logic [DATA_W-1:0] key_in;
  logic [DATA_W-1:0] value_in;

  // scan bookkeeping
  logic [CW-1:0] idx;
  logic          found;
  logic [AW-1:0] hit_slot;
  logic [AW-1:0] lru_slot;
  logic          free_found;
  logic [AW-1:0] free_slot;

  // store port
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_value;
  logic [AW-1:0]     wr_slot;
  logic              finish;
  logic              can_load;

  // compare stage, one entry behind the read address
  logic [CW-1:0] idx_m1;
  logic [AW-1:0] cmp_slot;
  logic          cmp_active;
  logic          cmp_valid;
  logic [RW-1:0] cmp_rank;
  logic [CW-1:0] count_m1;
  logic [RW-1:0] hit_rank;

  // eviction decision
  logic [CMPW-1:0] cap_x;
  logic [CMPW-1:0] eff_cap;
  logic            need_evict;
  logic [CW-1:0]   count_next;

  lrukv_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (finish),
    .wr_addr  (wr_slot),
    .wr_key   (key_in),
    .wr_value (value_in),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // effective capacity: zero acts as one, saturates at the store depth
  always_comb begin
    cap_x = CMPW'(capacity);
    if (cap_x == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_x > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
    need_evict = (CMPW'(count) >= eff_cap) && (count != '0);
  end

  assign idx_m1     = idx - CW'(1);
  assign cmp_slot   = idx_m1[AW-1:0];
  assign cmp_active = (state == ST_SCAN) && (idx != '0);
  assign cmp_valid  = valid[cmp_slot];
  assign cmp_rank   = rank[cmp_slot];
  assign count_m1   = count - CW'(1);
  assign hit_rank   = rank[hit_slot];

  // output register may load when empty or being drained this cycle
  assign can_load = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == CW'(MAX_ENTRIES)) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (!found && need_evict) begin
          state_next = ST_EVICT;
        end else if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_EVICT: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    rd_addr  = lru_slot;
    finish   = 1'b0;
    unique case (state)
      ST_IDLE:    in_stall = 1'b0;
      ST_SCAN:    rd_addr = idx[AW-1:0];
      ST_RESOLVE: finish = can_load && (found || !need_evict);
      ST_EVICT:   finish = can_load;
      default:    in_stall = 1'b1;
    endcase
  end

  // target slot: matched entry, evicted entry, or lowest free entry
  always_comb begin
    if (found) begin
      wr_slot = hit_slot;
    end else if (state == ST_EVICT) begin
      wr_slot = lru_slot;
    end else begin
      wr_slot = free_slot;
    end
    count_next = count;
    if (!found && (state == ST_RESOLVE)) count_next = count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // payload latch on input transfer
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      key_in   <= key;
      value_in <= value;
    end
  end

  // scan: first matching key, oldest valid entry, first free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if ((state == ST_IDLE) && in_valid) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      idx <= idx + CW'(1);
      if (cmp_active) begin
        if (cmp_valid && (rd_key == key_in) && !found) begin
          found <= 1'b1;
        end
        if (!cmp_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_active) begin
      if (cmp_valid && (rd_key == key_in) && !found) hit_slot <= cmp_slot;
      if (cmp_valid && (CW'(cmp_rank) == count_m1)) lru_slot <= cmp_slot;
      if (!cmp_valid && !free_found) free_slot <= cmp_slot;
    end
  end

  // recency and valid update when the step commits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (finish) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (AW'(i) == wr_slot) begin
          rank[i] <= '0;
        end else if (valid[i] && (!found || (rank[i] < hit_rank))) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
      valid[wr_slot] <= 1'b1;
      count          <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit       <= found;
      evicted   <= (state == ST_EVICT);
      occupancy <= OCC_W'(count_next);
      if (state == ST_EVICT) begin
        evicted_key   <= rd_key;
        evicted_value <= rd_value;
      end else begin
        evicted_key   <= '0;
        evicted_value <= '0;
      end
    end
  end

  // occupancy always equals the number of valid entries
  a_count_matches_valid: assert property (
    @(posedge clk) disable iff (rst) $countones(valid) == int'(count)
  ) else $error("occupancy out of step with valid bits");

  a_count_bound: assert property (
    @(posedge clk) disable iff (rst) count <= CW'(MAX_ENTRIES)
  ) else $error("occupancy above store depth");

  a_hit_no_evict: assert property (
    @(posedge clk) disable iff (rst) (out_valid && hit) |-> !evicted
  ) else $error("hit reported with eviction");

  a_busy_after_transfer: assert property (
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall
  ) else $error("new transfer taken during a lookup");

endmodule

// ----- tb/lru_key_value_cache_unit_tb.sv -----
module lru_key_value_cache_unit_tb;
  import lrukv_pkg::*;

  localparam int ENTRIES     = 8;
  // drain tail: worst result latency plus a little slack
  localparam int TAIL_CYCLES = ENTRIES + 6;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int POOL_DEPTH  = 12;
  localparam int HOLD_CYCLES = 300;

  // what one access reports
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [DATA_W-1:0] ev_key;
    logic [DATA_W-1:0] ev_value;
    logic [OCC_W-1:0]  occ;
  } access_outcome_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CFG_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     hit;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;
  logic signed [DATA_W-1:0] evicted_value;
  logic [OCC_W-1:0]         occupancy;

  // shadow copy of the cache contents and recency ranks
  logic [DATA_W-1:0] slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_value [ENTRIES];
  bit                slot_live  [ENTRIES];
  int unsigned       slot_rank  [ENTRIES];
  int unsigned       live_count;
  logic [CFG_W-1:0]  capacity_reg;

  // outcomes of accepted accesses, oldest first
  access_outcome_t pending_outcomes[$];

  // keys reused often so that hits and recency reordering happen
  logic [DATA_W-1:0] key_pool [POOL_DEPTH];
  int                pool_span;

  // idling knobs, percent of cycles
  int send_gap_pct;
  int stall_pct;
  // long receiver hold, handed over to the stall process
  int hold_request;
  int hold_left;

  int cycle_count;
  int mismatches;
  int accesses_sent;
  int results_seen;
  int hits_predicted;
  int evictions_predicted;
  int capacity_writes;

  lru_key_value_cache_unit #(
    .MAX_ENTRIES(ENTRIES)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key          (key),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .evicted      (evicted),
    .evicted_key  (evicted_key),
    .evicted_value(evicted_value),
    .occupancy    (occupancy)
  );

  always #2 clk = ~clk;

  // one lookup/insert against the shadow cache, returns what the block must report
  function automatic access_outcome_t lru_access(input logic [DATA_W-1:0] k,
                                                 input logic [DATA_W-1:0] v);
    access_outcome_t res;
    int              slot;
    bit              found;
    bit              have;
    int unsigned     oldest;
    int unsigned     limit;
    res    = '0;
    slot   = 0;
    found  = 1'b0;
    have   = 1'b0;
    oldest = 0;
    // lowest-numbered live entry with a matching key
    for (int i = 0; i < ENTRIES; i++)
      if (!found && slot_live[i] && slot_key[i] == k) begin
        slot  = i;
        found = 1'b1;
      end
    if (found) begin
      res.hit          = 1'b1;
      slot_value[slot] = v;
      // everything more recent than the hit entry ages by one
      limit = slot_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_rank[i] < limit) slot_rank[i]++;
      slot_rank[slot] = 0;
    end else begin
      // capacity zero acts as one, anything above the store size saturates
      if (capacity_reg == 0) limit = 1;
      else if (capacity_reg > ENTRIES) limit = ENTRIES;
      else limit = 32'(capacity_reg);
      if (live_count >= limit && live_count > 0) begin
        // evict the highest rank, first such entry on a tie
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (!have || slot_rank[i] > oldest)) begin
            oldest = slot_rank[i];
            slot   = i;
            have   = 1'b1;
          end
        if (have) begin
          res.evicted     = 1'b1;
          res.ev_key      = slot_key[slot];
          res.ev_value    = slot_value[slot];
          slot_live[slot] = 1'b0;
          live_count--;
        end
      end
      // no eviction: take the lowest free entry
      if (!have)
        for (int i = 0; i < ENTRIES; i++)
          if (!have && !slot_live[i]) begin
            slot = i;
            have = 1'b1;
          end
      if (have) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_rank[i]++;
        slot_key[slot]   = k;
        slot_value[slot] = v;
        slot_live[slot]  = 1'b1;
        slot_rank[slot]  = 0;
        live_count++;
      end
    end
    res.occ = live_count[OCC_W-1:0];
    return res;
  endfunction

  // mostly pool keys, some fresh random keys, a few corner patterns
  function automatic logic [DATA_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return key_pool[$urandom_range(0, pool_span - 1)];
    if (roll < 95) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
    // a span near the store size mixes hits with evictions
    pool_span = $urandom_range(6, POOL_DEPTH);
  endtask

  // present one key/value pair, with random idle cycles first, until it transfers
  task automatic offer_access(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
    access_outcome_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    predicted = lru_access(k, v);
    pending_outcomes.push_back(predicted);
    accesses_sent++;
    if (predicted.hit) hits_predicted++;
    if (predicted.evicted) evictions_predicted++;
  endtask

  // stop offering and wait until every outstanding result has come back
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // capacity changes only while the block is idle
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    quiesce();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    capacity_reg = cap;
    capacity_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_accesses(input int count);
    for (int i = 0; i < count; i++) begin
      // a new pool now and then flushes the cache through evictions
      if (i % 90 == 0) refresh_pool();
      offer_access(pick_key(), $urandom);
    end
  endtask

  // small capacities first, while the cache still fills from empty
  task automatic test_directed_corners();
    send_gap_pct = 0;
    stall_pct    = 0;
    // capacity zero behaves as one
    write_capacity(4'd0);
    offer_access(32'h0000_0000, 32'h0000_0000);
    offer_access(32'h7fff_ffff, 32'h8000_0000);
    offer_access(32'h7fff_ffff, 32'h0000_0001);
    write_capacity(4'd2);
    offer_access(32'h8000_0000, 32'h7fff_ffff);
    offer_access(32'hffff_ffff, 32'hffff_ffff);
    offer_access(32'h8000_0000, 32'h1234_5678);
    offer_access(32'h0000_0000, 32'h55aa_55aa);
    // above the store size saturates, fill all entries
    write_capacity(4'd15);
    for (int i = 1; i <= 6; i++) offer_access(i, 32'hf000_0000 | i);
    offer_access(32'h8000_0000, 32'h0f0f_0f0f);
    offer_access(32'haaaa_aaaa, 32'h5555_5555);
    offer_access(32'h0000_0001, 32'hdead_beef);
    // capacity lowered below occupancy: one eviction per miss, occupancy holds
    write_capacity(4'd1);
    offer_access(32'h5555_5555, 32'haaaa_aaaa);
    offer_access(32'h0000_0002, 32'h0000_0000);
    offer_access(32'h0000_0006, 32'hffff_ffff);
    offer_access(32'h0000_0006, 32'h8000_0000);
    write_capacity(4'd8);
    offer_access(32'h0000_0000, 32'h7fff_ffff);
    offer_access(32'h0000_0003, 32'h0000_0001);
  endtask

  task automatic test_no_idling();
    send_gap_pct = 0;
    stall_pct    = 0;
    write_capacity(4'd8);
    run_random_accesses(200);
    write_capacity(4'd3);
    run_random_accesses(200);
  endtask

  // random capacity per segment, idling as given
  task automatic test_idling(input int gap, input int stall);
    send_gap_pct = gap;
    stall_pct    = stall;
    for (int s = 0; s < 3; s++) begin
      write_capacity(CFG_W'($urandom_range(0, 15)));
      run_random_accesses(120);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_long_hold();
    send_gap_pct = 0;
    stall_pct    = 0;
    quiesce();
    hold_request = HOLD_CYCLES;
    run_random_accesses(40);
  endtask

  // bursts separated by full drains
  task automatic test_pause_and_resume();
    send_gap_pct = 10;
    stall_pct    = 30;
    for (int r = 0; r < 8; r++) begin
      run_random_accesses(30);
      if (r % 2 == 1) write_capacity(CFG_W'($urandom_range(0, 15)));
      else quiesce();
    end
  endtask

  // receiver side: long hold when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // compare every result transfer with the oldest outstanding outcome
  always @(posedge clk) begin : check_results
    access_outcome_t want;
    bit              bad;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%b evicted=%b key=%h value=%h occ=%0d",
                   hit, evicted, evicted_key, evicted_value, occupancy);
      end else begin
        want = pending_outcomes.pop_front();
        bad  = (hit !== want.hit) || (evicted !== want.evicted) ||
               (evicted_key !== want.ev_key) || (evicted_value !== want.ev_value) ||
               (occupancy !== want.occ);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d wrong, expected: hit=%b evicted=%b key=%h value=%h occ=%0d",
                     results_seen, want.hit, want.evicted, want.ev_key, want.ev_value,
                     want.occ);
            $display("  actual: hit=%b evicted=%b key=%h value=%h occ=%0d",
                     hit, evicted, evicted_key, evicted_value, occupancy);
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    key          = '0;
    value        = '0;
    out_stall    = 1'b0;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_request = 0;
    hold_left    = 0;
    cycle_count  = 0;
    mismatches   = 0;
    accesses_sent       = 0;
    results_seen        = 0;
    hits_predicted      = 0;
    evictions_predicted = 0;
    capacity_writes     = 0;
    // shadow state after reset; key and value storage is never read unwritten
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_rank[i] = 0;
    end
    live_count   = 0;
    capacity_reg = CAP_RESET;
    refresh_pool();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_no_idling();
    test_idling(70, 0);
    test_idling(0, 70);
    test_idling(28, 28);
    test_long_hold();
    test_pause_and_resume();
    quiesce();

    // anything still waiting is a lost result
    if (pending_outcomes.size() != 0) mismatches += pending_outcomes.size();

    $display("%0d accesses checked: %0d hits, %0d evictions, %0d capacity writes",
             results_seen, hits_predicted, evictions_predicted, capacity_writes);
    $display("idle and stall mixes, a long receiver hold and drained bursts; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lrukv_pkg.sv
hw/rtl/lrukv_store.sv
hw/rtl/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_tb.sv
